### rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int SPQ_DATA_W   = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_ctrl_t;

endpackage

### rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holding an entry and its occupancy.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_ctrl_t                    ctrl,
    input  logic signed [SPQ_DATA_W-1:0] new_value,
    input  logic signed [SPQ_DATA_W-1:0] new_priority,
    input  logic                         left_occ,
    input  logic                         left_gt,
    input  logic signed [SPQ_DATA_W-1:0] left_value,
    input  logic signed [SPQ_DATA_W-1:0] left_priority,
    input  logic                         right_occ,
    input  logic signed [SPQ_DATA_W-1:0] right_value,
    input  logic signed [SPQ_DATA_W-1:0] right_priority,
    output logic                         occ,
    output logic                         gt,
    output logic signed [SPQ_DATA_W-1:0] value,
    output logic signed [SPQ_DATA_W-1:0] prio
);

    logic                         occ_reg, occ_next;
    logic signed [SPQ_DATA_W-1:0] value_reg, value_next;
    logic signed [SPQ_DATA_W-1:0] prio_reg, prio_next;

    // Entry here leaves after the new one: strictly larger number.
    assign gt    = occ_reg && (prio_reg > new_priority);
    assign occ   = occ_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.ins)
        begin
            if (left_gt)
            begin
                // make room: take the neighbour's entry
                occ_next   = 1'b1;
                value_next = left_value;
                prio_next  = left_priority;
            end
            else if (left_occ && (gt || !occ_reg))
            begin
                occ_next   = 1'b1;
                value_next = new_value;
                prio_next  = new_priority;
            end
        end
        else if (ctrl.rem)
        begin
            occ_next   = right_occ;
            value_next = right_value;
            prio_next  = right_priority;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

### rtl/stable_priority_queue.sv
// stable_priority_queue: bounded, stable priority queue built as a chain of cells.
// Result: a result word is registered in the cycle after its input word is accepted.
// Throughput: one insert or remove per cycle while in_stall is low; every cell updates in parallel
// from its neighbours and the broadcast word, and one output register sits behind.
// Reset: rst_n (asynchronous, active low) empties the queue and the output
// register at once; stored payload is left as it was.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic signed [SPQ_DATA_W-1:0] item_value,
    input  logic signed [SPQ_DATA_W-1:0] item_priority,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SPQ_DATA_W-1:0] removed_value,
    output logic [1:0]                   status
);

    // Per-cell views; cell 0 is the head of the queue.
    logic                         occ   [CAPACITY];
    logic                         gt    [CAPACITY];
    logic signed [SPQ_DATA_W-1:0] value [CAPACITY];
    logic signed [SPQ_DATA_W-1:0] prio  [CAPACITY];

    logic        accept;
    logic        full;
    logic        empty;
    spq_ctrl_t   ctrl;
    spq_status_t status_next;

    logic                         out_valid_reg;
    logic signed [SPQ_DATA_W-1:0] removed_value_reg, removed_value_next;
    spq_status_t                  status_reg;

    // Input is held only while a result word sits unread in the output register.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Occupancy is a thermometer code, so its ends give full and empty.
    assign full  = occ[CAPACITY-1];
    assign empty = !occ[0];

    assign ctrl.ins = accept && (mode == MODE_INSERT) && !full;
    assign ctrl.rem = accept && (mode == MODE_REMOVE) && !empty;

    // The new word is broadcast; each cell decides locally whether it shifts
    // toward the tail, loads the new entry, or (on removal) pulls from the tail side.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         l_occ, l_gt, r_occ;
        logic signed [SPQ_DATA_W-1:0] l_val, l_pri, r_val, r_pri;

        if (i == 0)
        begin : g_head
            assign l_occ = 1'b1;
            assign l_gt  = 1'b0;
            assign l_val = item_value;
            assign l_pri = item_priority;
        end
        else
        begin : g_body
            assign l_occ = occ[i-1];
            assign l_gt  = gt[i-1];
            assign l_val = value[i-1];
            assign l_pri = prio[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_occ = 1'b0;
            assign r_val = value[i];
            assign r_pri = prio[i];
        end
        else
        begin : g_inner
            assign r_occ = occ[i+1];
            assign r_val = value[i+1];
            assign r_pri = prio[i+1];
        end

        spq_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .new_value      (item_value),
            .new_priority   (item_priority),
            .left_occ       (l_occ),
            .left_gt        (l_gt),
            .left_value     (l_val),
            .left_priority  (l_pri),
            .right_occ      (r_occ),
            .right_value    (r_val),
            .right_priority (r_pri),
            .occ            (occ[i]),
            .gt             (gt[i]),
            .value          (value[i]),
            .prio           (prio[i])
        );
    end

    // Result word for the accepted item.
    always_comb
    begin
        removed_value_next = '0;
        if (mode == MODE_INSERT)
        begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next        = ST_REMOVED;
            removed_value_next = value[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_value_reg <= removed_value_next;
            status_reg        <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_value_reg;
    assign status        = status_reg;

endmodule

### rtl/spq_checker.sv
// spq_checker: port-level assertions for stable_priority_queue, bound to the top.
// Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [SPQ_DATA_W-1:0] removed_value,
    input logic [1:0]                   status
);

    // Every accepted word yields a result word next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after accepted word");

    // Input is only held back by an unread result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // Only a successful removal carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_REMOVED)) |-> (removed_value == '0))
        else $error("non-zero value on non-removal result");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(removed_value)))
        else $error("result changed while stalled");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .status        (status)
);
